[src/kps_pkg.sv]
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types and constants of the matrix keypad scanner: field widths,
// scan phase encoding, register indexes and keypad size codes.
// ----------------------------------------------------------------------------
package kps_pkg;

  // Payload widths
  localparam int unsigned RowW     = 5;
  localparam int unsigned ColW     = 4;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Matrix limits and key table depth
  localparam int unsigned MaxLines     = 5;
  localparam int unsigned MaxColumns   = 4;
  localparam int unsigned TableEntries = 20;
  localparam int unsigned TableIdxW    = $clog2(TableEntries);

  // Key code reported when no key was seen
  localparam logic [CodeW-1:0] NoKey = 8'hFF;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgKeypadSize  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKeyTableLow = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKeyTableMid = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKeyTableHi  = 3'd4;

  // Keypad size codes (any other code acts as 4x4)
  localparam logic [1:0] Size4x3 = 2'd1;
  localparam logic [1:0] Size5x3 = 2'd2;

  // Scan phases
  typedef enum logic [1:0] {
    PhDrive    = 2'd0,
    PhCheck    = 2'd1,
    PhDebounce = 2'd2,
    PhRelease  = 2'd3
  } phase_e;

endpackage

[src/kps_ifs.sv]
// ----------------------------------------------------------------------------
// kps channel interfaces
// Valid/ready channels of the keypad scanner: pin samples in, scan results
// out, and the register write channel.
// ----------------------------------------------------------------------------

// Pin sample channel
interface kps_sample_if;
  logic                          valid;
  logic                          ready;
  logic [kps_pkg::RowW-1:0]      row_levels;
  logic                          ms_tick;

  modport source (output valid, output row_levels, output ms_tick, input ready);
  modport sink   (input valid, input row_levels, input ms_tick, output ready);
endinterface

// Scan result channel
interface kps_result_if;
  logic                          valid;
  logic                          ready;
  logic [kps_pkg::ColW-1:0]      column_drive;
  logic                          scan_done;
  logic                          key_found;
  logic [kps_pkg::CodeW-1:0]     key_code;

  modport source (output valid, output column_drive, output scan_done,
                  output key_found, output key_code, input ready);
  modport sink   (input valid, input column_drive, input scan_done,
                  input key_found, input key_code, output ready);
endinterface

// Register write channel
interface kps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kps_pkg::CfgIdxW-1:0]   index;
  logic [kps_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/matrix_keypad_scanner.sv]
// The result of an accepted sample beat is registered and valid the next cycle.
// Throughput: one sample per cycle unless the sink stalls; the scan state
// advances once per beat; the result register frees whenever the sink takes it.
// Register writes are taken in any cycle and act from the next beat on.
// Reset (rst_ni low, asynchronous) clears the registers, drops the held key,
// puts the scan in the drive phase at column 0, line 0, and empties the result.
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Column-driving keypad scanner with millisecond debounce and release wait;
// reports the last key found at the end of every full scan.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  kps_cfg_if.sink             cfg_i,
  kps_sample_if.sink          sample_i,
  kps_result_if.source        result_o
);

  localparam logic [3:0] MaxLinesW = 4'(kps_pkg::MaxLines);

  // Configuration registers
  logic [1:0]                 keypad_size_q;
  logic [7:0]                 debounce_ms_q;
  logic [63:0]                key_table_low_q;
  logic [63:0]                key_table_mid_q;
  logic [31:0]                key_table_high_q;

  // Scan state
  kps_pkg::phase_e            phase_q, phase_d;
  logic [1:0]                 col_q, col_d;
  logic [2:0]                 line_q, line_d;
  logic [7:0]                 cnt_q, cnt_d;
  logic [kps_pkg::CodeW-1:0]  held_q, held_d;
  logic                       seen_q, seen_d;

  // Result register
  logic                       out_valid_q;
  logic [kps_pkg::ColW-1:0]   drive_q;
  logic                       done_q;
  logic                       found_q;
  logic [kps_pkg::CodeW-1:0]  code_q;

  logic                       in_fire;
  logic [3:0]                 lines;
  logic [2:0]                 cols;
  logic [3:0]                 used_cols;
  logic [3:0]                 drive;
  logic                       line_bit;
  logic                       hit;
  logic                       line_last;
  logic                       col_last;
  logic [4:0]                 tbl_idx;
  logic [kps_pkg::CodeW-1:0]  tbl_code;
  logic [kps_pkg::CodeW-1:0]  key_entries [kps_pkg::TableEntries];
  logic [159:0]               tbl_flat;
  logic [7:0]                 cnt_inc;
  logic                       advance;
  logic                       done;
  logic                       found;
  logic [kps_pkg::CodeW-1:0]  code;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keypad_size_q    <= '0;
      debounce_ms_q    <= '0;
      key_table_low_q  <= '0;
      key_table_mid_q  <= '0;
      key_table_high_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        kps_pkg::CfgKeypadSize:  keypad_size_q    <= cfg_i.data[1:0];
        kps_pkg::CfgDebounceMs:  debounce_ms_q    <= cfg_i.data[7:0];
        kps_pkg::CfgKeyTableLow: key_table_low_q  <= cfg_i.data;
        kps_pkg::CfgKeyTableMid: key_table_mid_q  <= cfg_i.data;
        kps_pkg::CfgKeyTableHi:  key_table_high_q <= cfg_i.data[31:0];
        default: ;
      endcase
    end
  end

  // Accept a sample whenever the result register is free or being drained
  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign in_fire        = sample_i.valid && sample_i.ready;

  // Matrix geometry for the current size
  assign lines = (keypad_size_q == kps_pkg::Size5x3) ? 4'd5 : 4'd4;
  assign cols  = (keypad_size_q == kps_pkg::Size4x3 ||
                  keypad_size_q == kps_pkg::Size5x3) ? 3'd3 : 3'd4;
  assign used_cols = (cols == 3'd3) ? 4'h7 : 4'hF;
  assign drive     = used_cols & ~(4'b0001 << col_q);

  // Level of the line under test; lines past the pins read high
  assign line_bit = (4'(line_q) < 4'(kps_pkg::RowW)) ?
                    sample_i.row_levels[line_q] : 1'b1;

  assign hit = (4'(line_q) < lines) && (3'(col_q) < cols) &&
               (4'(line_q) < MaxLinesW) && !line_bit;

  assign line_last = !((4'(line_q) + 4'd1) < lines);
  assign col_last  = !((3'(col_q) + 3'd1) < cols);

  // Key table lookup at line*columns+column
  assign tbl_flat = {key_table_high_q, key_table_mid_q, key_table_low_q};
  always_comb begin
    for (int i = 0; i < kps_pkg::TableEntries; i++) begin
      key_entries[i] = tbl_flat[8*i +: 8];
    end
  end
  assign tbl_idx  = 5'(line_q) * 5'(cols) + 5'(col_q);
  assign tbl_code = (tbl_idx < 5'(kps_pkg::TableEntries)) ?
                    key_entries[tbl_idx[kps_pkg::TableIdxW-1:0]] : kps_pkg::NoKey;

  // Saturating debounce count
  assign cnt_inc = (sample_i.ms_tick && cnt_q != 8'hFF) ? cnt_q + 8'd1 : cnt_q;

  // Next scan state and result
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    line_d  = line_q;
    cnt_d   = cnt_q;
    held_d  = held_q;
    seen_d  = seen_q;
    advance = 1'b0;
    done    = 1'b0;
    found   = 1'b0;
    code    = kps_pkg::NoKey;

    unique case (phase_q)
      kps_pkg::PhDrive: begin
        line_d  = '0;
        phase_d = kps_pkg::PhCheck;
      end
      kps_pkg::PhCheck: begin
        if (hit) begin
          held_d  = tbl_code;
          seen_d  = 1'b1;
          cnt_d   = '0;
          phase_d = (debounce_ms_q == 8'd0) ? kps_pkg::PhRelease : kps_pkg::PhDebounce;
        end else begin
          advance = 1'b1;
        end
      end
      kps_pkg::PhDebounce: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= debounce_ms_q) begin
          phase_d = kps_pkg::PhRelease;
        end
      end
      kps_pkg::PhRelease: begin
        advance = line_bit;
      end
    endcase

    // Step to the next line, then the next column, then end the scan
    if (advance) begin
      if (!line_last) begin
        line_d  = line_q + 3'd1;
        phase_d = kps_pkg::PhCheck;
      end else begin
        line_d  = '0;
        phase_d = kps_pkg::PhDrive;
        if (!col_last) begin
          col_d = col_q + 2'd1;
        end else begin
          col_d = '0;
          done  = 1'b1;
        end
      end
    end

    // Report and drop the held key at the end of a scan
    if (done) begin
      found  = seen_q;
      code   = seen_q ? held_q : kps_pkg::NoKey;
      held_d = kps_pkg::NoKey;
      seen_d = 1'b0;
    end
  end

  // Scan state advances once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kps_pkg::PhDrive;
      col_q   <= '0;
      line_q  <= '0;
      cnt_q   <= '0;
      held_q  <= kps_pkg::NoKey;
      seen_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      line_q  <= line_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
      seen_q  <= seen_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      drive_q <= drive;
      done_q  <= done;
      found_q <= found;
      code_q  <= code;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.column_drive = drive_q;
  assign result_o.scan_done    = done_q;
  assign result_o.key_found    = found_q;
  assign result_o.key_code     = code_q;

`ifndef NO_ASSERTIONS
  // A key is only reported at the end of a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.key_found |-> result_o.scan_done)
    else $error("key reported outside a scan end");

  // No key seen means the held code is the empty code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> held_q == kps_pkg::NoKey)
    else $error("held key without a seen flag");

  // The drive phase always starts at the first line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == kps_pkg::PhDrive |-> line_q == 3'd0)
    else $error("drive phase with nonzero line");

  // Every accepted beat leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted beat produced no result");
`endif

endmodule
